FILE: rtl/core/fpe_pkg.sv
// ----------------------------------------------------------------------------
// fpe_pkg
// Shared types and constants for the frustum plane extractor.
// ----------------------------------------------------------------------------
package fpe_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;
    localparam int MINLEN_W      = 17;
    localparam int PLANE_W       = 3;
    localparam logic [MINLEN_W-1:0] MINLEN_RESET = 17'd7;
    localparam logic [PLANE_W-1:0]  PLANE_LAST   = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                store;
        logic                load;
        logic                sq;
        logic                rinit;
        logic                rstep;
        logic                dinit;
        logic                dstep;
        logic                dwrite;
        logic [1:0]          k;
        logic [PLANE_W-1:0]  plane;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scaled;
    } t_stat;

    // Matrix row that is combined with row 3 for a given plane.
    function automatic logic [1:0] plane_src(input logic [PLANE_W-1:0] plane);
        logic [1:0] src;
        case (plane)
            3'd0, 3'd1: src = 2'd2;
            3'd2, 3'd3: src = 2'd0;
            default:    src = 2'd1;
        endcase
        return src;
    endfunction

endpackage

FILE: rtl/core/fpe_datapath.sv
// ----------------------------------------------------------------------------
// fpe_datapath
// Matrix store, plane sums, square accumulation, root and divide units.
// ----------------------------------------------------------------------------
module fpe_datapath #(
    parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fpe_pkg::t_cmd                      i_cmd,
    output fpe_pkg::t_stat                     o_stat,
    input  logic [1:0]                         i_row_index,
    input  logic signed [fpe_pkg::COEF_W-1:0]  i_entry_col0,
    input  logic signed [fpe_pkg::COEF_W-1:0]  i_entry_col1,
    input  logic signed [fpe_pkg::COEF_W-1:0]  i_entry_col2,
    input  logic signed [fpe_pkg::COEF_W-1:0]  i_entry_col3,
    input  logic                               i_cfg_we,
    input  logic [fpe_pkg::MINLEN_W-1:0]       i_cfg_data,
    output logic signed [fpe_pkg::COEF_W-1:0]  o_coef_a,
    output logic signed [fpe_pkg::COEF_W-1:0]  o_coef_b,
    output logic signed [fpe_pkg::COEF_W-1:0]  o_coef_c,
    output logic signed [fpe_pkg::COEF_W-1:0]  o_coef_d
);
    import fpe_pkg::*;

    localparam int DW = COEF_W + FRAC_BITS;

    logic signed [COEF_W-1:0] r_mat [4][4];
    logic signed [COEF_W-1:0] r_p   [4];
    logic [MINLEN_W-1:0]      r_min;
    logic [63:0]              r_sq;
    logic [63:0]              r_acc;
    logic [63:0]              r_rad;
    logic [33:0]              r_rem;
    logic [31:0]              r_root;
    logic [DW-1:0]            r_dvd;
    logic [31:0]              r_drem;
    logic [DW-1:0]            r_quo;
    logic                     r_neg;

    logic [1:0]               src;
    logic signed [COEF_W:0]   sum [4];
    logic signed [COEF_W-1:0] sat [4];
    logic [35:0]              rem2;
    logic [35:0]              trial;
    logic [32:0]              drem2;
    logic                     qbit;
    logic signed [COEF_W-1:0] pk;
    logic [COEF_W-1:0]        mag;
    logic signed [COEF_W-1:0] qres;
    logic signed [63:0]       prod;

    assign src = plane_src(i_cmd.plane);

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (i_cmd.plane[0]) begin
                sum[j] = {r_mat[3][j][COEF_W-1], r_mat[3][j]}
                       - {r_mat[src][j][COEF_W-1], r_mat[src][j]};
            end else begin
                sum[j] = {r_mat[3][j][COEF_W-1], r_mat[3][j]}
                       + {r_mat[src][j][COEF_W-1], r_mat[src][j]};
            end
            if (sum[j][COEF_W] != sum[j][COEF_W-1]) begin
                sat[j] = sum[j][COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}}
                                        : {1'b0, {(COEF_W-1){1'b1}}};
            end else begin
                sat[j] = sum[j][COEF_W-1:0];
            end
        end
    end

    assign pk   = r_p[i_cmd.k];
    assign mag  = pk[COEF_W-1] ? COEF_W'(-pk) : COEF_W'(pk);
    assign prod = (i_cmd.k == 2'd3) ? 64'sd0 : pk * pk;

    // One root digit per step.
    assign rem2  = {r_rem, r_rad[63:62]};
    assign trial = {2'b00, r_root, 2'b01};

    // One quotient bit per step.
    assign drem2 = {r_drem, r_dvd[DW-1]};
    assign qbit  = (drem2 >= {1'b0, r_root});

    always_comb begin
        if (r_neg) begin
            if (r_quo > DW'(33'h080000000)) begin
                qres = {1'b1, {(COEF_W-1){1'b0}}};
            end else begin
                qres = COEF_W'(-r_quo[COEF_W-1:0]);
            end
        end else begin
            if (r_quo > DW'(32'h7FFFFFFF)) begin
                qres = {1'b0, {(COEF_W-1){1'b1}}};
            end else begin
                qres = r_quo[COEF_W-1:0];
            end
        end
    end

    assign o_stat.scaled = (r_root > {{(32-MINLEN_W){1'b0}}, r_min});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MINLEN_RESET;
        end else if (i_cfg_we) begin
            r_min <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mat[i_row_index][0] <= i_entry_col0;
            r_mat[i_row_index][1] <= i_entry_col1;
            r_mat[i_row_index][2] <= i_entry_col2;
            r_mat[i_row_index][3] <= i_entry_col3;
        end
        if (i_cmd.load) begin
            for (int j = 0; j < 4; j++) begin
                r_p[j] <= sat[j];
            end
            r_sq  <= '0;
            r_acc <= '0;
        end
        if (i_cmd.sq) begin
            r_sq  <= 64'(prod);
            r_acc <= r_acc + r_sq;
        end
        if (i_cmd.rinit) begin
            r_rad  <= r_acc;
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.rstep) begin
            r_rad <= {r_rad[61:0], 2'b00};
            if (rem2 >= trial) begin
                r_rem  <= 34'(rem2 - trial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem2[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
        if (i_cmd.dinit) begin
            r_dvd  <= {mag, {FRAC_BITS{1'b0}}};
            r_drem <= '0;
            r_quo  <= '0;
            r_neg  <= pk[COEF_W-1];
        end
        if (i_cmd.dstep) begin
            r_dvd  <= {r_dvd[DW-2:0], 1'b0};
            r_drem <= qbit ? 32'(drem2 - {1'b0, r_root}) : drem2[31:0];
            r_quo  <= {r_quo[DW-2:0], qbit};
        end
        if (i_cmd.dwrite) begin
            r_p[i_cmd.k] <= qres;
        end
    end

    assign o_coef_a = r_p[0];
    assign o_coef_b = r_p[1];
    assign o_coef_c = r_p[2];
    assign o_coef_d = r_p[3];

endmodule

FILE: rtl/core/fpe_ctrl.sv
// ----------------------------------------------------------------------------
// fpe_ctrl
// Sequencer for the six planes: sums, squares, root, four divides if scaled, emit.
// ----------------------------------------------------------------------------
module fpe_ctrl #(
    parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_compute_now,
    output logic                         o_busy,
    output fpe_pkg::t_cmd                o_cmd,
    input  fpe_pkg::t_stat               i_stat,
    output logic                         o_valid,
    output logic [fpe_pkg::PLANE_W-1:0]  o_plane_id,
    output logic                         o_was_scaled,
    output logic                         o_last_plane
);
    import fpe_pkg::*;

    localparam int DW = COEF_W + FRAC_BITS;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] DIV_LAST  = CW'(DW - 1);
    localparam logic [CW-1:0] ROOT_LAST = CW'(31);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_SQ, S_RINIT, S_ROOT, S_CHECK,
        S_DINIT, S_DIV, S_DWRITE, S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [PLANE_W-1:0]  r_plane, n_plane;
    logic [1:0]          r_k, n_k;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_scaled, n_scaled;
    logic                r_valid;
    logic                accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_plane  = r_plane;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_scaled = r_scaled;
        o_cmd        = '0;
        o_cmd.store  = accept;
        o_cmd.k      = r_k;
        o_cmd.plane  = r_plane;
        case (r_state)
            S_IDLE: begin
                if (accept && i_compute_now) begin
                    n_plane = '0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_k        = '0;
                n_state    = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_k      = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = S_RINIT;
                end
            end
            S_RINIT: begin
                o_cmd.rinit = 1'b1;
                n_cnt       = '0;
                n_state     = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.rstep = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == ROOT_LAST) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_scaled = i_stat.scaled;
                n_k      = '0;
                n_state  = i_stat.scaled ? S_DINIT : S_EMIT;
            end
            S_DINIT: begin
                o_cmd.dinit = 1'b1;
                n_cnt       = '0;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.dstep = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DWRITE;
                end
            end
            S_DWRITE: begin
                o_cmd.dwrite = 1'b1;
                n_k          = r_k + 2'd1;
                n_state      = (r_k == 2'd3) ? S_EMIT : S_DINIT;
            end
            S_EMIT: begin
                if (r_plane == PLANE_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_plane = r_plane + 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_plane  <= '0;
            r_k      <= '0;
            r_cnt    <= '0;
            r_scaled <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_plane  <= n_plane;
            r_k      <= n_k;
            r_cnt    <= n_cnt;
            r_scaled <= n_scaled;
            r_valid  <= (n_state == S_EMIT);
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_plane_id   = r_plane;
    assign o_was_scaled = r_scaled;
    assign o_last_plane = (r_plane == PLANE_LAST);

endmodule

FILE: rtl/core/frustum_plane_extractor.sv
// ----------------------------------------------------------------------------
// frustum_plane_extractor
// A row without compute_now is stored in the accepting cycle; busy stays low.
// With compute_now, each plane runs through the one-bit-per-cycle root (32
// steps) and, when normalized, through the shared restoring divider
// (32 + FRAC_BITS steps per coefficient, Q16.16 by default). Reset
// (synchronous, active low) returns the sequencer to idle and sets
// min_length to 7; the matrix store is not cleared. The receiver cannot
// stall: each plane is shown for exactly one cycle on o_valid.
// ----------------------------------------------------------------------------
module frustum_plane_extractor #(
    parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [1:0]                         i_row_index,
    input  logic signed [fpe_pkg::COEF_W-1:0]  i_entry_col0,
    input  logic signed [fpe_pkg::COEF_W-1:0]  i_entry_col1,
    input  logic signed [fpe_pkg::COEF_W-1:0]  i_entry_col2,
    input  logic signed [fpe_pkg::COEF_W-1:0]  i_entry_col3,
    input  logic                               i_compute_now,
    input  logic                               i_cfg_we,
    input  logic [fpe_pkg::MINLEN_W-1:0]       i_cfg_data,
    output logic                               o_valid,
    output logic [fpe_pkg::PLANE_W-1:0]        o_plane_id,
    output logic signed [fpe_pkg::COEF_W-1:0]  o_coef_a,
    output logic signed [fpe_pkg::COEF_W-1:0]  o_coef_b,
    output logic signed [fpe_pkg::COEF_W-1:0]  o_coef_c,
    output logic signed [fpe_pkg::COEF_W-1:0]  o_coef_d,
    output logic                               o_was_scaled,
    output logic                               o_last_plane
);
    import fpe_pkg::*;

    // The controller issues one command set per cycle; the datapath reports
    // back only whether the current normal length clears the threshold.
    t_cmd  cmd;
    t_stat stat;

    // Sequencer: walks each plane through sum, square accumulation, root,
    // threshold check, four divides if scaled and the one-cycle result strobe.
    fpe_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_compute_now (i_compute_now),
        .o_busy        (o_busy),
        .o_cmd         (cmd),
        .i_stat        (stat),
        .o_valid       (o_valid),
        .o_plane_id    (o_plane_id),
        .o_was_scaled  (o_was_scaled),
        .o_last_plane  (o_last_plane)
    );

    // Datapath: the four stored rows, the saturating plane sums, one
    // multiplier for the squares, the digit-serial root and the divider.
    // The coefficient registers hold the plane being shown during the strobe.
    fpe_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_row_index  (i_row_index),
        .i_entry_col0 (i_entry_col0),
        .i_entry_col1 (i_entry_col1),
        .i_entry_col2 (i_entry_col2),
        .i_entry_col3 (i_entry_col3),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_coef_a     (o_coef_a),
        .o_coef_b     (o_coef_b),
        .o_coef_c     (o_coef_c),
        .o_coef_d     (o_coef_d)
    );

endmodule

FILE: rtl/core/fpe_checker.sv
// ----------------------------------------------------------------------------
// fpe_checker
// Port-level checks on the request and result sequencing.
// ----------------------------------------------------------------------------
module fpe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       i_compute_now,
    input logic       o_busy,
    input logic       o_valid,
    input logic [2:0] o_plane_id,
    input logic       o_last_plane
);

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result strobe outside a run");

    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_compute_now) |=> (o_busy && !o_valid))
        else $error("compute request did not start a run");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_last_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_plane == (o_plane_id == 3'd5)))
        else $error("last plane flag does not match plane id");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_plane) |=> !o_busy)
        else $error("busy after last plane");

endmodule

bind frustum_plane_extractor fpe_checker u_fpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .i_compute_now (i_compute_now),
    .o_busy        (o_busy),
    .o_valid       (o_valid),
    .o_plane_id    (o_plane_id),
    .o_last_plane  (o_last_plane)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: frustum plane extractor testbench
// Loads matrix rows through the start/busy handshake and predicts the six
// planes of every compute request in a local fixed-point model. Each plane
// that leaves on o_valid is checked field by field against the oldest
// prediction. A directed table runs first, then random rows under several
// min_length settings.
// ----------------------------------------------------------------------------
module tb;
    import fpe_pkg::*;

    localparam int          FRAC       = FRAC_BITS_DEF;
    localparam int          IDLE_LIMIT = 4000;
    localparam logic [31:0] Q_MAX      = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN      = 32'h8000_0000;
    localparam logic [31:0] Q_ONE      = 32'h0001_0000;
    localparam int          DIR_LEN    = 20;

    // One plane as it leaves the block.
    typedef struct packed {
        logic [PLANE_W-1:0] id;
        logic [31:0]        a;
        logic [31:0]        b;
        logic [31:0]        c;
        logic [31:0]        d;
        logic               scaled;
        logic               last;
    } plane_t;

    // One row of the directed table. zero_exp marks the all-zero matrix,
    // whose planes are typed in rather than predicted.
    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        logic        go;
        logic        zero_exp;
    } dir_req_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [1:0]           i_row_index;
    logic signed [31:0]   i_entry_col0;
    logic signed [31:0]   i_entry_col1;
    logic signed [31:0]   i_entry_col2;
    logic signed [31:0]   i_entry_col3;
    logic                 i_compute_now;
    logic                 i_cfg_we;
    logic [MINLEN_W-1:0]  i_cfg_data;
    logic                 o_valid;
    logic [PLANE_W-1:0]   o_plane_id;
    logic signed [31:0]   o_coef_a;
    logic signed [31:0]   o_coef_b;
    logic signed [31:0]   o_coef_c;
    logic signed [31:0]   o_coef_d;
    logic                 o_was_scaled;
    logic                 o_last_plane;

    // Local copy of the matrix and threshold, and the planes still owed.
    logic [31:0]          mat [4][4];
    logic [MINLEN_W-1:0]  min_len;
    plane_t               planes_due [$];
    int                   mismatches;
    int                   idle_cycles;
    dir_req_t             dir_tab [DIR_LEN];

    frustum_plane_extractor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_row_index   (i_row_index),
        .i_entry_col0  (i_entry_col0),
        .i_entry_col1  (i_entry_col1),
        .i_entry_col2  (i_entry_col2),
        .i_entry_col3  (i_entry_col3),
        .i_compute_now (i_compute_now),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_plane_id    (o_plane_id),
        .o_coef_a      (o_coef_a),
        .o_coef_b      (o_coef_b),
        .o_coef_c      (o_coef_c),
        .o_coef_d      (o_coef_d),
        .o_was_scaled  (o_was_scaled),
        .o_last_plane  (o_last_plane)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Saturate an exact sum to the signed 32-bit range.
    function automatic logic [31:0] clamp32(input longint v);
        if (v > longint'(32'sh7fff_ffff)) return Q_MAX;
        if (v < -longint'(64'h8000_0000)) return Q_MIN;
        return v[31:0];
    endfunction

    // Integer square root, one result bit per pass.
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // (|p| << FRAC) / len toward zero, signed, saturated.
    function automatic logic [31:0] scale_coef(input logic [31:0] p, input logic [63:0] len);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        neg = p[31];
        mag = neg ? 64'(-longint'($signed(p))) : 64'(p);
        q   = (mag << FRAC) / len;
        if (neg) begin
            if (q > 64'h8000_0000) return Q_MIN;
            return 32'(-longint'(q));
        end
        if (q > 64'h7fff_ffff) return Q_MAX;
        return q[31:0];
    endfunction

    // Gribb-Hartmann extraction of all six planes from the local matrix.
    task automatic push_planes();
        plane_t      pl;
        logic [31:0] p [4];
        logic [63:0] sumsq;
        logic [63:0] len;
        logic [1:0]  src;
        longint      base;
        longint      other;
        for (int id = 0; id < 6; id++) begin
            // near/far use row 2, left/right row 0, bottom/top row 1.
            src = (id < 2) ? 2'd2 : (id < 4) ? 2'd0 : 2'd1;
            for (int k = 0; k < 4; k++) begin
                base  = longint'($signed(mat[3][k]));
                other = longint'($signed(mat[src][k]));
                p[k]  = clamp32((id % 2) ? base - other : base + other);
            end
            sumsq = '0;
            for (int k = 0; k < 3; k++)
                sumsq += 64'(longint'($signed(p[k])) * longint'($signed(p[k])));
            len       = floor_root(sumsq);
            pl.id     = PLANE_W'(id);
            pl.scaled = (len > 64'(min_len));
            if (pl.scaled) begin
                for (int k = 0; k < 4; k++) p[k] = scale_coef(p[k], len);
            end
            pl.a    = p[0];
            pl.b    = p[1];
            pl.c    = p[2];
            pl.d    = p[3];
            pl.last = (pl.id == PLANE_LAST);
            planes_due.push_back(pl);
        end
    endtask

    // Present one request at the falling edge and hold it until accepted.
    // start stays high when the next request follows with no gap.
    task automatic send_row(input logic [1:0] row, input logic [31:0] c0, input logic [31:0] c1,
                            input logic [31:0] c2, input logic [31:0] c3, input logic go,
                            input logic zero_exp);
        plane_t pl;
        int     gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start       = 1'b1;
        i_row_index   = row;
        i_entry_col0  = c0;
        i_entry_col1  = c1;
        i_entry_col2  = c2;
        i_entry_col3  = c3;
        i_compute_now = go;
        do @(posedge i_clk); while (o_busy);
        mat[row][0] = c0;
        mat[row][1] = c1;
        mat[row][2] = c2;
        mat[row][3] = c3;
        if (go) begin
            if (zero_exp) begin
                // A zero matrix gives zero planes, too short to normalize.
                for (int id = 0; id < 6; id++) begin
                    pl        = '0;
                    pl.id     = PLANE_W'(id);
                    pl.last   = (pl.id == PLANE_LAST);
                    planes_due.push_back(pl);
                end
            end else begin
                push_planes();
            end
        end
        @(negedge i_clk);
    endtask

    // Write min_length once the block has drained. A row without compute
    // causes no plane, so a few extra cycles are allowed before the write.
    task automatic set_min_len(input logic [MINLEN_W-1:0] v);
        i_start = 1'b0;
        while (planes_due.size() != 0 || o_busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        min_len    = v;
    endtask

    // Random matrix element. Mostly modest values near unity, some full
    // range words, and some large terms paired with tiny ones so that both
    // the threshold and the quotient clamps are exercised.
    function automatic logic [31:0] rand_entry(input int mode);
        case (mode)
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 2 * 32'h0004_0000)) - 32'sh0004_0000);
            2:       return 32'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
        endcase
    endfunction

    // Result checking: every strobe must match the oldest prediction.
    always @(posedge i_clk) begin
        plane_t want;
        if (i_rst_n && o_valid) begin
            if (planes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected plane id %0d", o_plane_id);
            end else begin
                want = planes_due.pop_front();
                if (want.id !== o_plane_id || want.a !== o_coef_a || want.b !== o_coef_b
                    || want.c !== o_coef_c || want.d !== o_coef_d
                    || want.scaled !== o_was_scaled || want.last !== o_last_plane) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("plane mismatch: exp id=%0d a=%h b=%h c=%h d=%h s=%b l=%b | got id=%0d a=%h b=%h c=%h d=%h s=%b l=%b",
                                 want.id, want.a, want.b, want.c, want.d, want.scaled,
                                 want.last, o_plane_id, o_coef_a, o_coef_b, o_coef_c,
                                 o_coef_d, o_was_scaled, o_last_plane);
                end
            end
        end
    end

    // Watchdog: cycles in which neither a request nor a plane moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[frustum_plane_extractor] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        int n_done;
        logic [MINLEN_W-1:0] phase_len [4];
        mismatches    = 0;
        idle_cycles   = 0;
        min_len       = MINLEN_RESET;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_row_index   = '0;
        i_entry_col0  = '0;
        i_entry_col1  = '0;
        i_entry_col2  = '0;
        i_entry_col3  = '0;
        i_compute_now = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++) mat[r][k] = '0;

        // Every row is written before the first compute, so no unwritten
        // store entry is ever read.
        dir_tab[0]  = '{2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0};
        dir_tab[1]  = '{2'd1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0};
        dir_tab[2]  = '{2'd2, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0};
        dir_tab[3]  = '{2'd3, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1};
        // Unit planes: an identity-like matrix normalizes cleanly.
        dir_tab[4]  = '{2'd0, Q_ONE, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0};
        dir_tab[5]  = '{2'd1, 32'd0, Q_ONE, 32'd0, 32'd0, 1'b0, 1'b0};
        dir_tab[6]  = '{2'd2, 32'd0, 32'd0, Q_ONE, 32'd0, 1'b0, 1'b0};
        dir_tab[7]  = '{2'd3, 32'd0, 32'd0, 32'd0, Q_ONE, 1'b1, 1'b0};
        // Extremes: sums and differences clamp at both limits.
        dir_tab[8]  = '{2'd3, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0};
        dir_tab[9]  = '{2'd2, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0};
        dir_tab[10] = '{2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, 1'b0};
        dir_tab[11] = '{2'd1, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1, 1'b0};
        dir_tab[12] = '{2'd3, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1, 1'b0};
        // Normals just around the reset threshold of 7.
        dir_tab[13] = '{2'd0, 32'd3, 32'd2, 32'd1, 32'd5, 1'b0, 1'b0};
        dir_tab[14] = '{2'd1, 32'd4, 32'd4, 32'd4, 32'd9, 1'b0, 1'b0};
        dir_tab[15] = '{2'd2, 32'd1, 32'd0, 32'd0, 32'd1, 1'b0, 1'b0};
        dir_tab[16] = '{2'd3, 32'd4, 32'd3, 32'd0, 32'd2, 1'b1, 1'b0};
        // Tiny normal with a large distance drives the quotient into clamp.
        dir_tab[17] = '{2'd3, 32'd8, 32'd0, 32'd0, 32'h4000_0000, 1'b0, 1'b0};
        dir_tab[18] = '{2'd0, 32'd0, 32'd0, 32'd0, 32'hc000_0000, 1'b0, 1'b0};
        dir_tab[19] = '{2'd2, 32'd0, 32'd0, 32'd0, Q_MIN, 1'b1, 1'b0};

        phase_len[0] = 17'd0;
        phase_len[1] = 17'd65536;
        phase_len[2] = 17'h1_ffff;
        phase_len[3] = 17'($urandom_range(1, 4096));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at the reset threshold.
        foreach (dir_tab[i])
            send_row(dir_tab[i].row, dir_tab[i].c0, dir_tab[i].c1, dir_tab[i].c2,
                     dir_tab[i].c3, dir_tab[i].go, dir_tab[i].zero_exp);

        // Random part in five phases: reset threshold carried over, then
        // zero, one, the 17-bit maximum and a random value.
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) set_min_len(phase_len[ph - 1]);
            n_done = 0;
            while (n_done < 60) begin
                mode = $urandom_range(0, 9);
                mode = (mode < 2) ? 0 : (mode < 6) ? 1 : (mode < 9) ? 2 : 3;
                send_row(2'($urandom_range(0, 3)), rand_entry(mode), rand_entry(mode),
                         rand_entry(mode),
                         ($urandom_range(0, 3) == 0) ? rand_entry(0) : rand_entry(mode),
                         ($urandom_range(0, 3) == 0), 1'b0);
                n_done++;
            end
        end

        i_start = 1'b0;
        while (planes_due.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("[frustum_plane_extractor] OK");
        end else begin
            $display("[frustum_plane_extractor] ERROR");
        end
        $finish;
    end

endmodule
